[design/bpfa_pkg.sv]
// Shared types, codes and helpers of the bitmap page frame allocator.
`default_nettype none
package bpfa_pkg;

	localparam int NUM_REGIONS      = 2;
	localparam int PAGES_PER_REGION = 4096;
	localparam int PAGE_SHIFT       = 12;
	localparam int ROW_BITS         = 128;
	localparam int BYTES_PER_ROW    = ROW_BITS / 8;
	localparam int ROWS_PER_REGION  = PAGES_PER_REGION / ROW_BITS;
	localparam int MEM_ROWS         = NUM_REGIONS * ROWS_PER_REGION;

	localparam int REG_W   = $clog2(NUM_REGIONS);
	localparam int ROW_W   = $clog2(ROWS_PER_REGION);
	localparam int MADDR_W = $clog2(MEM_ROWS);
	localparam int BYTE_W  = $clog2(BYTES_PER_ROW);
	localparam int BIT_W   = $clog2(ROW_BITS);
	localparam int PAGE_W  = $clog2(PAGES_PER_REGION);
	localparam int HINT_W  = 9;
	localparam int PAGES_W = 13;
	localparam int CIDX_W  = 3;

	// request modes
	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_FREE    = 2'd1;
	localparam logic [1:0] MODE_RESERVE = 2'd2;

	// result codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_NO_FREE      = 2'd1;
	localparam logic [1:0] ST_NO_REGION    = 2'd2;
	localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_REGION_COUNT = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_BASE0        = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_PAGES0       = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_BASE1        = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_PAGES1       = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] address;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] page_address;
	} rsp_t;

	typedef struct packed {
		logic               en;
		logic [MADDR_W-1:0] addr;
	} bmp_rd_t;

	typedef struct packed {
		logic                en;
		logic [MADDR_W-1:0]  addr;
		logic [ROW_BITS-1:0] data;
	} bmp_wr_t;

	// Pages a region can really hold: clipped to the region size and to the 4 GiB top.
	function automatic logic [PAGES_W-1:0] usable_pages(input logic [31:0] base,
			input logic [PAGES_W-1:0] pages);
		logic [PAGES_W-1:0] n;
		logic [20:0] room;
		n = (pages > PAGES_W'(PAGES_PER_REGION)) ? PAGES_W'(PAGES_PER_REGION) : pages;
		room = 21'h100000 - {1'b0, base[31:12]} - {20'd0, |base[11:0]};
		if (room < {8'd0, n}) begin
			n = room[PAGES_W-1:0];
		end
		return n;
	endfunction

endpackage
`default_nettype wire

[design/bpfa_bitmap.sv]
// Used-page bitmap storage: one-port-read, one-port-write RAM with per-row valid flags.
`default_nettype none
module bpfa_bitmap (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire bpfa_pkg::bmp_rd_t   rd,
	output logic [bpfa_pkg::ROW_BITS-1:0] rd_data,
	input  wire bpfa_pkg::bmp_wr_t   wr
);
	import bpfa_pkg::*;

	logic [ROW_BITS-1:0] mem [MEM_ROWS];
	logic [ROW_BITS-1:0] mem_q;
	logic [MEM_ROWS-1:0] row_vld_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			mem_q <= mem[rd.addr];
		end
	end

	// a row never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				row_vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_q <= row_vld_q[rd.addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? mem_q : '0;

endmodule
`default_nettype wire

[design/bpfa_row_search.sv]
// Finds the first free usable page in one bitmap row and returns the updated row.
`default_nettype none
module bpfa_row_search (
	input  wire [bpfa_pkg::ROW_BITS-1:0] data,
	input  wire [bpfa_pkg::ROW_W-1:0]    row,
	input  wire                          wrap_pass,
	input  wire [bpfa_pkg::HINT_W-1:0]   hint,
	input  wire [bpfa_pkg::PAGES_W-1:0]  npages,
	output logic                         found,
	output logic [bpfa_pkg::PAGE_W-1:0]  page,
	output logic [bpfa_pkg::ROW_BITS-1:0] new_data
);
	import bpfa_pkg::*;

	logic [PAGES_W-1:0]     row_first;
	logic [PAGES_W-1:0]     rem;
	logic [BIT_W:0]         lim;
	logic [ROW_BITS-1:0]    free_bits;
	logic [BYTES_PER_ROW-1:0] byte_sel;
	logic [BYTE_W-1:0]      fj;
	logic [2:0]             fb;
	logic [7:0]             sel_byte;

	always_comb begin
		row_first = {1'b0, row, {BIT_W{1'b0}}};
		rem = npages - row_first;
		if (npages <= row_first) begin
			lim = '0;
		end else if (rem >= PAGES_W'(ROW_BITS)) begin
			lim = (BIT_W+1)'(ROW_BITS);
		end else begin
			lim = rem[BIT_W:0];
		end
		for (int i = 0; i < ROW_BITS; i++) begin
			free_bits[i] = !data[i] && ((BIT_W+1)'(i) < lim);
		end
	end

	// hint row: first visit covers bytes from the hint up, the wrap visit the bytes below it
	always_comb begin
		for (int j = 0; j < BYTES_PER_ROW; j++) begin
			if (row == hint[HINT_W-1:BYTE_W]) begin
				byte_sel[j] = wrap_pass ? (BYTE_W'(j) < hint[BYTE_W-1:0])
				                        : (BYTE_W'(j) >= hint[BYTE_W-1:0]);
			end else begin
				byte_sel[j] = 1'b1;
			end
		end
	end

	always_comb begin
		found = 1'b0;
		fj    = '0;
		for (int j = BYTES_PER_ROW - 1; j >= 0; j--) begin
			if (byte_sel[j] && (|free_bits[j*8 +: 8])) begin
				found = 1'b1;
				fj    = BYTE_W'(j);
			end
		end
		sel_byte = free_bits[{fj, 3'd0} +: 8];
		fb = '0;
		for (int b = 7; b >= 0; b--) begin
			if (sel_byte[b]) begin
				fb = 3'(b);
			end
		end
		page     = {row, fj, fb};
		new_data = data | (ROW_BITS'(1) << {fj, fb});
	end

endmodule
`default_nettype wire

[design/bitmap_page_frame_allocator.sv]
// Top level of the bitmap page frame allocator: control, region registers and hints.
`default_nettype none
// Usage
//   Request channel: drive cmd (mode, address) with start; an item is taken on a clock
//   edge where start is high and busy is low. busy drops in the cycle that carries done.
//   Result channel: rsp is valid for exactly the one cycle in which done is high; there
//   is no back-pressure, the receiver must take it then.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Write registers only while the block is idle.
// Request steps (accept edge to done)
//   unused mode: done from idle. free / reserve: region match, bitmap read, write.
//   allocate: done from idle with no region in use, otherwise a row scan. The bitmap is
//   held as 128-page rows, one row read per cycle from the bitmap RAM; a region search
//   reads at most 33 rows (hint row up to the end, then row 0 up to the hint row again),
//   and each search waits on the registered RAM read. Worst case is two full region searches.
// Throughput: one item at a time; busy is already low while done is high, so the next
//   item can be taken at the edge that ends the done cycle.
// Reset: all registers, search hints and per-row valid flags clear, so every page
//   reads as free right away; there is no RAM clearing pass.
module bitmap_page_frame_allocator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire bpfa_pkg::cmd_t          cmd,
	output logic                         done,
	output bpfa_pkg::rsp_t               rsp,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [bpfa_pkg::CIDX_W-1:0]   cfg_index,
	input  wire [31:0]                   cfg_data
);
	import bpfa_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_LOCATE = 2'd2;
	localparam logic [1:0] S_RMW    = 2'd3;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_PER_REGION - 1);

	// region registers
	logic [1:0]         rcount_q;
	logic [31:0]        base_q  [NUM_REGIONS];
	logic [PAGES_W-1:0] pages_q [NUM_REGIONS];
	logic [HINT_W-1:0]  hint_q  [NUM_REGIONS];

	// control
	logic [1:0]        state_q;
	logic [1:0]        mode_q;
	logic [31:0]       addr_q;
	logic [REG_W-1:0]  reg_q;
	logic [ROW_W-1:0]  srow_q;
	logic              spass_q;
	logic              issue_q;
	logic [PAGE_W-1:0] page_q;
	logic              done_q;
	rsp_t              rsp_q;

	// scan read pipeline
	logic              rd_vld_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              pass_s1;
	logic              last_s1;

	logic [1:0]          act;
	logic [PAGES_W-1:0]  n_eff [NUM_REGIONS];
	logic [HINT_W-1:0]   hint_cur;
	logic [ROW_W-1:0]    hrow;
	logic                last_step;

	logic [31:0]         a_aligned;
	logic [32:0]         loc_diff;
	logic                loc_hit;
	logic [REG_W-1:0]    loc_reg;
	logic [PAGE_W-1:0]   loc_page;

	bmp_rd_t             rd;
	bmp_wr_t             wr;
	logic [ROW_BITS-1:0] rd_data_s1;

	logic                found;
	logic [PAGE_W-1:0]   found_page;
	logic [ROW_BITS-1:0] alloc_row;
	logic [31:0]         alloc_addr;

	logic [ROW_BITS-1:0] rmw_mask;
	logic                cur_bit;
	logic                rmw_write;

	// a region count above the number of regions acts as all regions
	assign act = (rcount_q > 2'(NUM_REGIONS)) ? 2'(NUM_REGIONS) : rcount_q;

	always_comb begin
		for (int r = 0; r < NUM_REGIONS; r++) begin
			n_eff[r] = usable_pages(base_q[r], pages_q[r]);
		end
	end

	assign hint_cur  = hint_q[reg_q];
	assign hrow      = hint_cur[HINT_W-1:BYTE_W];
	assign last_step = spass_q && (srow_q == hrow);

	// free / reserve: first active region that holds the page
	assign a_aligned = {addr_q[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

	always_comb begin
		loc_hit  = 1'b0;
		loc_reg  = '0;
		loc_page = '0;
		loc_diff = '0;
		for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
			loc_diff = {1'b0, a_aligned} - {1'b0, base_q[r]};
			if ((2'(r) < act) && !loc_diff[32]
					&& (loc_diff[31:0] < {7'd0, n_eff[r], {PAGE_SHIFT{1'b0}}})) begin
				loc_hit  = 1'b1;
				loc_reg  = REG_W'(r);
				loc_page = loc_diff[PAGE_SHIFT +: PAGE_W];
			end
		end
	end

	// bitmap read port: scan rows, or the located row
	always_comb begin
		rd.en   = 1'b0;
		rd.addr = {reg_q, srow_q};
		if (state_q == S_SCAN) begin
			rd.en = issue_q;
		end else if (state_q == S_LOCATE) begin
			rd.en   = loc_hit;
			rd.addr = {loc_reg, loc_page[PAGE_W-1:BIT_W]};
		end
	end

	bpfa_bitmap u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.rd_data (rd_data_s1),
		.wr      (wr)
	);

	bpfa_row_search u_search (
		.data      (rd_data_s1),
		.row       (row_s1),
		.wrap_pass (pass_s1),
		.hint      (hint_cur),
		.npages    (n_eff[reg_q]),
		.found     (found),
		.page      (found_page),
		.new_data  (alloc_row)
	);

	assign alloc_addr = base_q[reg_q] + {8'd0, found_page, {PAGE_SHIFT{1'b0}}};

	assign rmw_mask  = ROW_BITS'(1) << page_q[BIT_W-1:0];
	assign cur_bit   = rd_data_s1[page_q[BIT_W-1:0]];
	assign rmw_write = (mode_q == MODE_RESERVE) || cur_bit;

	// bitmap write port
	always_comb begin
		wr.en   = 1'b0;
		wr.addr = {reg_q, row_s1};
		wr.data = alloc_row;
		if (state_q == S_SCAN) begin
			wr.en = rd_vld_s1 && found;
		end else if (state_q == S_RMW) begin
			wr.en   = rmw_write;
			wr.addr = {reg_q, page_q[PAGE_W-1:BIT_W]};
			wr.data = (mode_q == MODE_RESERVE) ? (rd_data_s1 | rmw_mask)
			                                   : (rd_data_s1 & ~rmw_mask);
		end
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcount_q <= '0;
			for (int r = 0; r < NUM_REGIONS; r++) begin
				base_q[r]  <= '0;
				pages_q[r] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REGION_COUNT: rcount_q   <= cfg_data[1:0];
				CFG_BASE0:        base_q[0]  <= cfg_data;
				CFG_PAGES0:       pages_q[0] <= cfg_data[PAGES_W-1:0];
				CFG_BASE1:        base_q[1]  <= cfg_data;
				CFG_PAGES1:       pages_q[1] <= cfg_data[PAGES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// scan pipeline stage: which row the RAM output belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			row_s1    <= '0;
			pass_s1   <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN) && issue_q;
			row_s1    <= srow_q;
			pass_s1   <= spass_q;
			last_s1   <= last_step;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_ALLOC;
			addr_q  <= '0;
			reg_q   <= '0;
			srow_q  <= '0;
			spass_q <= 1'b0;
			issue_q <= 1'b0;
			page_q  <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
			for (int r = 0; r < NUM_REGIONS; r++) begin
				hint_q[r] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= cmd.mode;
						addr_q <= cmd.address;
						unique case (cmd.mode)
							MODE_ALLOC: begin
								if (act == 2'd0) begin
									done_q <= 1'b1;
									rsp_q  <= '{status: ST_NO_FREE, page_address: '0};
								end else begin
									reg_q   <= '0;
									srow_q  <= hint_q[0][HINT_W-1:BYTE_W];
									spass_q <= 1'b0;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							MODE_FREE, MODE_RESERVE: begin
								state_q <= S_LOCATE;
							end
							default: begin
								done_q <= 1'b1;
								rsp_q  <= '{status: ST_OK, page_address: '0};
							end
						endcase
					end
				end

				S_SCAN: begin
					// row walk: hint row to the last row, then row 0 back to the hint row
					if (issue_q) begin
						if (!spass_q) begin
							if (srow_q == LAST_ROW) begin
								spass_q <= 1'b1;
								srow_q  <= '0;
							end else begin
								srow_q <= srow_q + ROW_W'(1);
							end
						end else if (last_step) begin
							issue_q <= 1'b0;
						end else begin
							srow_q <= srow_q + ROW_W'(1);
						end
					end
					if (rd_vld_s1) begin
						if (found) begin
							hint_q[reg_q] <= found_page[PAGE_W-1:3];
							issue_q <= 1'b0;
							done_q  <= 1'b1;
							rsp_q   <= '{status: ST_OK, page_address: alloc_addr};
							state_q <= S_IDLE;
						end else if (last_s1) begin
							if ((reg_q == '0) && (act == 2'd2)) begin
								reg_q   <= REG_W'(1);
								srow_q  <= hint_q[1][HINT_W-1:BYTE_W];
								spass_q <= 1'b0;
								issue_q <= 1'b1;
							end else begin
								done_q  <= 1'b1;
								rsp_q   <= '{status: ST_NO_FREE, page_address: '0};
								state_q <= S_IDLE;
							end
						end
					end
				end

				S_LOCATE: begin
					if (loc_hit) begin
						reg_q   <= loc_reg;
						page_q  <= loc_page;
						state_q <= S_RMW;
					end else begin
						done_q  <= 1'b1;
						rsp_q   <= '{status: ST_NO_REGION, page_address: '0};
						state_q <= S_IDLE;
					end
				end

				S_RMW: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (rmw_write) begin
						rsp_q <= '{status: ST_OK, page_address: '0};
						// a freed page below the hint pulls the hint down
						if ((mode_q == MODE_FREE) && (page_q[PAGE_W-1:3] < hint_q[reg_q])) begin
							hint_q[reg_q] <= page_q[PAGE_W-1:3];
						end
					end else begin
						rsp_q <= '{status: ST_ALREADY_FREE, page_address: '0};
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// a result always comes with the sequencer back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while sequencer still busy");

	// a failed request never carries an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != ST_OK)) |-> (rsp.page_address == '0))
		else $error("failed request returned a page address");

	// bitmap is written only while a request is in flight, and never twice for one item
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (busy && !done))
		else $error("bitmap write outside a request");

	a_wr_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> !wr.en)
		else $error("two bitmap writes for one request");

endmodule
`default_nettype wire

[sim/tb_bitmap_page_frame_allocator.sv]
// Self-checking testbench for the bitmap page frame allocator: directed and random requests.
`timescale 1ns / 1ps
module tb_bitmap_page_frame_allocator;
	import bpfa_pkg::*;

	// mode 3 has no operation behind it: no state change, status ok
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// longest quiet stretch: sender gap plus a worst-case two-region allocate scan
	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		cmd_t cmd;
		bit   sync;	// hold this item until every earlier result is back
	} frame_req_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	cmd_t                cmd = '0;
	logic                cfg_valid = 1'b0;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [31:0]         cfg_data = '0;
	wire                 busy;
	wire                 done;
	rsp_t                rsp;
	wire                 cfg_ready;

	bitmap_page_frame_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Allocator mirror: region registers, used bits and byte hints
	// ---------------------------------------------------------------
	logic [1:0]  rgn_count;
	logic [31:0] rgn_base  [NUM_REGIONS];
	logic [12:0] rgn_pages [NUM_REGIONS];
	logic [7:0]  frame_used [NUM_REGIONS][PAGES_PER_REGION/8];
	logic [8:0]  scan_hint [NUM_REGIONS];

	frame_req_t req_q[$];		// items waiting for the driver
	rsp_t       outcome_q[$];	// predicted results, oldest first

	int launched = 0;	// items the driver has put on the bus
	int checked  = 0;	// results compared so far
	int fail_cnt = 0;
	int n_mode [4];
	int n_status [4];
	int n_setups = 0;

	// a count above NUM_REGIONS behaves as NUM_REGIONS
	function automatic int live_regions();
		return (rgn_count > NUM_REGIONS) ? NUM_REGIONS : int'(rgn_count);
	endfunction

	// page count clipped to the bitmap size and to the 4 GiB top
	function automatic int fit_pages(int r);
		longint unsigned room, n;
		room = (64'h1_0000_0000 - {32'd0, rgn_base[r]}) >> PAGE_SHIFT;
		n = rgn_pages[r];
		if (n > PAGES_PER_REGION) n = PAGES_PER_REGION;
		if (n > room) n = room;
		return int'(n);
	endfunction

	// first region, in order, holding the page of addr
	function automatic bit find_page(input logic [31:0] addr, output int r_hit, output int pg);
		longint unsigned a, base, span;
		r_hit = 0;
		pg = 0;
		a = {32'd0, addr[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
		for (int r = 0; r < live_regions(); r++) begin
			base = {32'd0, rgn_base[r]};
			span = fit_pages(r);
			span = span << PAGE_SHIFT;
			if (a >= base && a - base < span) begin
				r_hit = r;
				pg = int'((a - base) >> PAGE_SHIFT);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// lowest clear bit of one bitmap byte; a clear bit past the page count ends the byte
	function automatic bit claim_in_byte(input int r, input int b, input int n,
			output logic [31:0] pa);
		logic [7:0] v;
		int pg;
		pa = '0;
		v = frame_used[r][b];
		if (v == 8'hFF) return 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (!v[k]) begin
				pg = b * 8 + k;
				if (pg >= n) return 1'b0;
				frame_used[r][b][k] = 1'b1;
				pa = rgn_base[r] + (32'(pg) << PAGE_SHIFT);
				scan_hint[r] = 9'(b);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// next-fit: hint to end, then wrap from byte 0 up to the hint
	function automatic bit grab_frame(output logic [31:0] pa);
		int n, nb, h, stop;
		pa = '0;
		for (int r = 0; r < live_regions(); r++) begin
			n = fit_pages(r);
			nb = (n + 7) / 8;
			h = scan_hint[r];
			stop = (h < nb) ? h : nb;
			for (int b = h; b < nb; b++)
				if (claim_in_byte(r, b, n, pa)) return 1'b1;
			for (int b = 0; b < stop; b++)
				if (claim_in_byte(r, b, n, pa)) return 1'b1;
		end
		return 1'b0;
	endfunction

	// expected result of one request; updates the mirror
	function automatic rsp_t page_frame_outcome(cmd_t c);
		rsp_t o;
		int r, pg, b;
		logic [7:0] m;
		logic [31:0] pa;
		o.status = ST_OK;
		o.page_address = '0;
		case (c.mode)
		MODE_ALLOC: begin
			if (grab_frame(pa)) o.page_address = pa;
			else o.status = ST_NO_FREE;
		end
		MODE_FREE, MODE_RESERVE: begin
			if (!find_page(c.address, r, pg)) begin
				o.status = ST_NO_REGION;
			end else begin
				b = pg / 8;
				m = 8'(1 << (pg % 8));
				if (c.mode == MODE_RESERVE) begin
					// reserve never moves the hint
					frame_used[r][b] = frame_used[r][b] | m;
				end else if ((frame_used[r][b] & m) == 8'd0) begin
					o.status = ST_ALREADY_FREE;
				end else begin
					frame_used[r][b] = frame_used[r][b] & ~m;
					if (b < scan_hint[r]) scan_hint[r] = 9'(b);
				end
			end
		end
		default: ;
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------
	// Driver: bursts of items with random gaps, one item per handshake
	// ---------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;
	frame_req_t nxt;

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			// item taken at this edge: predict now, config cannot change under it
			if (start && !busy) begin
				outcome_q.push_back(page_frame_outcome(cmd));
				n_mode[cmd.mode]++;
			end
			if (start && busy) begin
				// hold the item until the block takes it
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (req_q.size() != 0 && (!req_q[0].sync || launched == checked)) begin
				nxt = req_q.pop_front();
				cmd <= nxt.cmd;
				start <= 1'b1;
				launched++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 16);
					// about one burst in four runs straight into the next
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compare every result, watch for a stalled run
	// ---------------------------------------------------------------
	rsp_t want;
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result with nothing outstanding: status %0d page_address %h",
						rsp.status, rsp.page_address);
					fail_cnt++;
				end else begin
					want = outcome_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_cnt++;
					end
					if (rsp.page_address !== want.page_address) begin
						$error("page_address: expected %h, got %h",
							want.page_address, rsp.page_address);
						fail_cnt++;
					end
					n_status[want.status]++;
					checked++;
				end
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, directed requests, random setups
	// ---------------------------------------------------------------
	task automatic push_req(input logic [1:0] mode, input logic [31:0] addr, input bit sync);
		frame_req_t q;
		q.cmd.mode = mode;
		q.cmd.address = addr;
		q.sync = sync;
		req_q.push_back(q);
	endtask

	// block idle: nothing queued, everything launched has answered
	task automatic wait_idle();
		while (req_q.size() != 0 || launched != checked) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_REGION_COUNT: rgn_count = val[1:0];
		CFG_BASE0:        rgn_base[0] = val;
		CFG_PAGES0:       rgn_pages[0] = val[12:0];
		CFG_BASE1:        rgn_base[1] = val;
		CFG_PAGES1:       rgn_pages[1] = val[12:0];
		default: ;
		endcase
	endtask

	task automatic set_regions(input logic [31:0] cnt, input logic [31:0] b0,
			input logic [31:0] p0, input logic [31:0] b1, input logic [31:0] p1);
		wait_idle();
		write_reg(CFG_REGION_COUNT, cnt);
		write_reg(CFG_BASE0, b0);
		write_reg(CFG_PAGES0, p0);
		write_reg(CFG_BASE1, b1);
		write_reg(CFG_PAGES1, p1);
		n_setups++;
	endtask

	// mostly pages in or just past a configured region; some wild addresses and modes
	task automatic push_random();
		frame_req_t q;
		int pick, r, lim, pg;
		pick = $urandom_range(0, 99);
		r = $urandom_range(0, NUM_REGIONS - 1);
		q.sync = ($urandom_range(0, 49) == 0);
		q.cmd.address = $urandom();
		if (pick < 40) q.cmd.mode = MODE_ALLOC;
		else if (pick < 70) q.cmd.mode = MODE_FREE;
		else if (pick < 88) q.cmd.mode = MODE_RESERVE;
		else if (pick < 93) q.cmd.mode = MODE_UNUSED;
		else q.cmd.mode = 2'($urandom_range(0, 3));
		if (pick >= 40 && pick < 88 && $urandom_range(0, 9) != 0) begin
			lim = (rgn_pages[r] > 48) ? 48 : int'(rgn_pages[r]);
			pg = $urandom_range(0, lim + 1);
			q.cmd.address = rgn_base[r] + (32'(pg) << PAGE_SHIFT) + $urandom_range(0, 4095);
		end
		req_q.push_back(q);
	endtask

	initial begin
		logic [31:0] b0, b1;
		int cnt;
		rgn_count = '0;
		for (int r = 0; r < NUM_REGIONS; r++) begin
			rgn_base[r] = '0;
			rgn_pages[r] = '0;
			scan_hint[r] = '0;
			for (int b = 0; b < PAGES_PER_REGION / 8; b++) frame_used[r][b] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			n_mode[i] = 0;
			n_status[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// out of reset no region is active: everything fails except the unused mode
		push_req(MODE_ALLOC, 32'd0, 1'b0);
		push_req(MODE_FREE, 32'd0, 1'b0);
		push_req(MODE_RESERVE, 32'd0, 1'b0);
		push_req(MODE_UNUSED, 32'hFFFF_FFFF, 1'b0);

		// nine pages crossing a byte boundary, then a two-page region at an unaligned base
		b0 = 32'h0010_0000;
		set_regions(2, b0, 9, 32'h8000_0123, 2);
		push_req(MODE_ALLOC, 32'd0, 1'b0);
		push_req(MODE_ALLOC, 32'd0, 1'b0);
		push_req(MODE_RESERVE, b0 + 32'h2ABC, 1'b0);	// offset bits ignored
		push_req(MODE_ALLOC, 32'd0, 1'b0);			// skips the reserved page
		push_req(MODE_FREE, b0 + 32'h1000, 1'b0);
		push_req(MODE_FREE, b0 + 32'h1000, 1'b0);		// double free
		push_req(MODE_FREE, 32'd0, 1'b0);			// below every region
		push_req(MODE_RESERVE, 32'hFFFF_FFFF, 1'b0);
		push_req(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1);
		// fill region 0, spill into region 1, then run out
		repeat (9) push_req(MODE_ALLOC, 32'd0, 1'b0);
		push_req(MODE_FREE, 32'h8000_1200, 1'b0);		// page 0 of the unaligned region
		push_req(MODE_FREE, b0, 1'b0);			// pulls region 0 hint back to byte 0
		push_req(MODE_ALLOC, 32'd0, 1'b0);
		push_req(MODE_ALLOC, 32'd0, 1'b0);

		// random setups; the bitmap carries over from one setup to the next
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			0: set_regions(2, $urandom() & 32'hFFFF_F000, $urandom_range(1, 40),
				$urandom(), $urandom_range(1, 40));
			// near the top: 8191 pages clip to the 8 that fit below 4 GiB
			1: set_regions(1, 32'hFFFF_8000, 32'h1FFF, $urandom(), PAGES_PER_REGION);
			// overlapping regions, and a count above the region limit
			2: begin
				b1 = {20'($urandom_range(0, 32'hEFFFF)), 12'h000};
				set_regions(3, b1, 24, b1 + 32'h4000, 24);
			end
			// full-size region at zero; second region starts at the last byte of memory
			3: set_regions(2, 32'd0, PAGES_PER_REGION, 32'hFFFF_FFFF, 32'h1FFF);
			// shrink region 0 below its hint, empty region 1
			4: set_regions(2, 32'd0, 5, $urandom(), 0);
			5: set_regions(0, $urandom(), $urandom_range(1, 64), $urandom(),
				$urandom_range(1, 64));
			6: set_regions(2, $urandom(), $urandom_range(1, 64), $urandom(),
				$urandom_range(1, 64));
			default: begin
				b1 = $urandom() & 32'h7FFF_F000;
				set_regions(2, b1, 8, b1 + 32'h0010_0000, 9);
			end
			endcase
			cnt = (rgn_count == 0) ? 20 : 80;
			repeat (cnt) push_random();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (outcome_q.size() != 0) begin
			$error("%0d results never arrived", outcome_q.size());
			fail_cnt++;
		end
		$display("Run covered %0d requests over %0d region setups: ", checked, n_setups,
			"%0d allocate, %0d free, %0d reserve, %0d unused mode",
			n_mode[MODE_ALLOC], n_mode[MODE_FREE],
			n_mode[MODE_RESERVE], n_mode[MODE_UNUSED]);
		$display("Outcomes: %0d ok, %0d no free page, %0d outside regions, %0d already free",
			n_status[ST_OK], n_status[ST_NO_FREE], n_status[ST_NO_REGION],
			n_status[ST_ALREADY_FREE]);
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
